// File: src/fsd_pkg.sv
// Package with shared constants and the letter order table for the decipher core.
`timescale 1ns / 1ps
package fsd_pkg;

	localparam int COUNT_BITS = 24;
	localparam int ALPHA_LEN = 26;
	localparam int IDX_W = $clog2(ALPHA_LEN);

	localparam logic [7:0] LETTER_A = 8'h61;
	localparam logic [7:0] LETTER_Z = 8'h7a;

	localparam logic [1:0] CMD_COUNT = 2'd0;
	localparam logic [1:0] CMD_DECODE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	function automatic logic [7:0] german_letter(input logic [IDX_W-1:0] rank);
		logic [7:0] l;
		begin
			case (rank)
				5'd0: l = "e";
				5'd1: l = "n";
				5'd2: l = "i";
				5'd3: l = "a";
				5'd4: l = "s";
				5'd5: l = "t";
				5'd6: l = "r";
				5'd7: l = "u";
				5'd8: l = "h";
				5'd9: l = "d";
				5'd10: l = "l";
				5'd11: l = "c";
				5'd12: l = "m";
				5'd13: l = "o";
				5'd14: l = "g";
				5'd15: l = "k";
				5'd16: l = "w";
				5'd17: l = "b";
				5'd18: l = "z";
				5'd19: l = "f";
				5'd20: l = "v";
				5'd21: l = "p";
				5'd22: l = "j";
				5'd23: l = "x";
				5'd24: l = "y";
				5'd25: l = "q";
				default: l = "e";
			endcase
			return l;
		end
	endfunction

endpackage

// File: src/fsd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module fsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [ADDR_W-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/frequency_substitution_decipher_core.sv
// Top level of the frequency-analysis substitution decipher core; it takes one word at a time.
// Count words of a lowercase letter, and decode words of one once ranked, hold busy in the cycle after acceptance.
// A decode word is strobed in the cycle after acceptance; a lowercase letter goes via ST_DEC_OUT.
// The first decode after reset, a clear or a count ranks all letters before its result is given.
// Reset clears the counters at once through per-letter valid bits; no clearing pass runs.
// Results are strobed on done for a single cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module frequency_substitution_decipher_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] cmd,
	input logic [7:0] data_byte,
	output logic done,
	output logic [7:0] plain_byte
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT_WR,
		ST_RANK_LOAD,
		ST_RANK_CI,
		ST_RANK_CMP,
		ST_DEC_ISSUE,
		ST_DEC_OUT
	} state_t;

	localparam logic [fsd_pkg::IDX_W-1:0] LAST_IDX = fsd_pkg::IDX_W'(fsd_pkg::ALPHA_LEN - 1);

	state_t state_q;
	logic [fsd_pkg::ALPHA_LEN-1:0] valid_q;
	logic map_ready_q;
	logic [7:0] byte_q;
	logic [fsd_pkg::IDX_W-1:0] i_q;
	logic [fsd_pkg::IDX_W-1:0] j_q;
	logic [fsd_pkg::IDX_W-1:0] rank_q;
	logic [fsd_pkg::COUNT_BITS-1:0] ci_q;

	logic cnt_we;
	logic [fsd_pkg::IDX_W-1:0] cnt_raddr;
	logic [fsd_pkg::COUNT_BITS-1:0] cnt_wdata;
	logic [fsd_pkg::COUNT_BITS-1:0] cnt_rdata;
	logic map_we;
	logic [fsd_pkg::IDX_W-1:0] map_raddr;
	logic [7:0] map_wdata;
	logic [7:0] map_rdata;

	logic in_lower;
	logic [fsd_pkg::IDX_W-1:0] in_idx;
	logic byte_lower;
	logic [fsd_pkg::IDX_W-1:0] byte_idx;
	logic [fsd_pkg::COUNT_BITS-1:0] cnt_eff_i;
	logic [fsd_pkg::COUNT_BITS-1:0] cnt_eff_j;
	logic [fsd_pkg::COUNT_BITS-1:0] cnt_eff_k;
	logic ranks_above;
	logic [fsd_pkg::IDX_W-1:0] rank_next;

	assign busy = (state_q != ST_IDLE);

	assign in_lower = (data_byte >= fsd_pkg::LETTER_A) && (data_byte <= fsd_pkg::LETTER_Z);
	assign in_idx = fsd_pkg::IDX_W'(data_byte - fsd_pkg::LETTER_A);
	assign byte_lower = (byte_q >= fsd_pkg::LETTER_A) && (byte_q <= fsd_pkg::LETTER_Z);
	assign byte_idx = fsd_pkg::IDX_W'(byte_q - fsd_pkg::LETTER_A);

	assign cnt_eff_i = valid_q[i_q] ? cnt_rdata : '0;
	assign cnt_eff_j = valid_q[j_q] ? cnt_rdata : '0;
	assign cnt_eff_k = valid_q[byte_idx] ? cnt_rdata : '0;
	assign ranks_above = (cnt_eff_j > ci_q) || ((cnt_eff_j == ci_q) && (j_q < i_q));
	assign rank_next = rank_q + fsd_pkg::IDX_W'(ranks_above);

	assign cnt_we = (state_q == ST_CNT_WR) && (cnt_eff_k != '1);
	assign cnt_wdata = cnt_eff_k + fsd_pkg::COUNT_BITS'(1);
	assign map_we = (state_q == ST_RANK_CMP) && (j_q == LAST_IDX);
	assign map_wdata = fsd_pkg::german_letter(rank_next);

	always_comb begin
		case (state_q)
			ST_RANK_LOAD: cnt_raddr = i_q;
			ST_RANK_CI: cnt_raddr = '0;
			ST_RANK_CMP: cnt_raddr = (j_q == LAST_IDX) ? i_q + fsd_pkg::IDX_W'(1) :
				j_q + fsd_pkg::IDX_W'(1);
			default: cnt_raddr = in_idx;
		endcase
	end

	assign map_raddr = (state_q == ST_DEC_ISSUE) ? byte_idx : in_idx;

	fsd_ram #(
		.WIDTH(fsd_pkg::COUNT_BITS),
		.DEPTH(fsd_pkg::ALPHA_LEN)
	) u_count_ram (
		.clk(clk),
		.we(cnt_we),
		.waddr(byte_idx),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	fsd_ram #(
		.WIDTH(8),
		.DEPTH(fsd_pkg::ALPHA_LEN)
	) u_map_ram (
		.clk(clk),
		.we(map_we),
		.waddr(i_q),
		.wdata(map_wdata),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			map_ready_q <= 1'b0;
			done <= 1'b0;
			plain_byte <= '0;
			byte_q <= '0;
			i_q <= '0;
			j_q <= '0;
			rank_q <= '0;
			ci_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						byte_q <= data_byte;
						case (cmd)
							fsd_pkg::CMD_COUNT: begin
								map_ready_q <= 1'b0;
								if (in_lower) begin
									state_q <= ST_CNT_WR;
								end
							end
							fsd_pkg::CMD_DECODE: begin
								if (!map_ready_q) begin
									i_q <= '0;
									state_q <= ST_RANK_LOAD;
								end else if (in_lower) begin
									state_q <= ST_DEC_OUT;
								end else begin
									done <= 1'b1;
									plain_byte <= data_byte;
								end
							end
							fsd_pkg::CMD_CLEAR: begin
								valid_q <= '0;
								map_ready_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CNT_WR: begin
					valid_q[byte_idx] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RANK_LOAD: begin
					state_q <= ST_RANK_CI;
				end
				ST_RANK_CI: begin
					ci_q <= cnt_eff_i;
					j_q <= '0;
					rank_q <= '0;
					state_q <= ST_RANK_CMP;
				end
				ST_RANK_CMP: begin
					rank_q <= rank_next;
					j_q <= j_q + fsd_pkg::IDX_W'(1);
					if (j_q == LAST_IDX) begin
						i_q <= i_q + fsd_pkg::IDX_W'(1);
						if (i_q == LAST_IDX) begin
							map_ready_q <= 1'b1;
							state_q <= ST_DEC_ISSUE;
						end else begin
							state_q <= ST_RANK_CI;
						end
					end
				end
				ST_DEC_ISSUE: begin
					if (byte_lower) begin
						state_q <= ST_DEC_OUT;
					end else begin
						done <= 1'b1;
						plain_byte <= byte_q;
						state_q <= ST_IDLE;
					end
				end
				ST_DEC_OUT: begin
					done <= 1'b1;
					plain_byte <= map_rdata;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
